// File: rtl/core/sfce_pkg.sv
package sfce_pkg;

  // Event kinds on the mode input.
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_FALL = 2'd1;
  localparam logic [1:0] MODE_RISE = 2'd2;

  // Flash command codes.
  localparam logic [7:0] CMD_PROGRAM  = 8'h02;
  localparam logic [7:0] CMD_READ     = 8'h03;
  localparam logic [7:0] CMD_STATUS   = 8'h05;
  localparam logic [7:0] CMD_ERASE_4K = 8'h20;

  localparam int unsigned SectorBits = 12;
  localparam logic [24:0] SectorBytes = 25'h1000;
  localparam logic [24:0] PosMax = 25'h1FFFFFF;
  localparam logic [7:0] ErasedByte = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming event
    logic exec;        // apply the latched event to the transaction state
    logic out_direct;  // issue a result word from the decoded reply
    logic out_mem;     // issue a result word from the array read data
    logic erase_load;  // load the sweep address with the sector base
    logic sweep_wr;    // write the erased value at the sweep address
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exch;
    logic read_hit;
    logic erase_go;
    logic sweep_end_erase;
    logic sweep_end_clear;
  } dp_status_t;

endpackage

// File: rtl/core/sfce_ctrl.sv
module sfce_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  sfce_pkg::dp_status_t   status_i,
  output sfce_pkg::ctrl_cmd_t    cmd_o
);
  import sfce_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_RESP   = 3'd3;
  localparam logic [2:0] ST_ERASE  = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        if (status_i.sweep_end_clear) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.exec = 1'b1;
        if (status_i.read_hit) begin
          state_d = ST_RESP;
        end else if (status_i.exch) begin
          cmd_o.out_direct = 1'b1;
          state_d          = ST_IDLE;
        end else if (status_i.erase_go) begin
          cmd_o.erase_load = 1'b1;
          state_d          = ST_ERASE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        cmd_o.out_mem = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_ERASE: begin
        cmd_o.sweep_wr = 1'b1;
        if (status_i.sweep_end_erase) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A read that hits the array always takes the response cycle next.
  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE && status_i.read_hit) |=> cmd_o.out_mem)
    else $error("read hit did not reach the response cycle");

  // No word is issued while the array is being swept.
  a_no_out_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep_wr |-> !(cmd_o.out_direct || cmd_o.out_mem || cmd_o.capture))
    else $error("output or capture during a sweep");

  // An erase sweep is only entered through a sector load.
  a_erase_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_ERASE) |-> $past(cmd_o.erase_load))
    else $error("erase sweep without sector load");

endmodule

// File: rtl/core/sfce_dp.sv
module sfce_dp #(
  parameter int unsigned FLASH_BYTES = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             mode_i,
  input  logic [7:0]             data_in_i,
  input  logic                   status_we_i,
  input  logic [7:0]             status_value_i,
  input  sfce_pkg::ctrl_cmd_t    cmd_i,
  output sfce_pkg::dp_status_t   status_o,
  output logic                   strobe_o,
  output logic [7:0]             data_out_o
);
  import sfce_pkg::*;

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam logic [25:0] FlashEnd = 26'(FLASH_BYTES);
  localparam logic [24:0] FlashEnd25 = 25'(FLASH_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(FLASH_BYTES - 1);

  logic [1:0]    mode_q;
  logic [7:0]    din_q;
  logic [7:0]    cmd_q, cmd_d;
  logic [23:0]   addr_q, addr_d;
  logic [24:0]   pos_q, pos_d;
  logic [7:0]    status_q;
  logic [AW-1:0] sweep_q;
  logic          strobe_q;
  logic [7:0]    data_out_q;

  logic [7:0]    flash_mem [FLASH_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic          exch;
  logic          data_ph;
  logic          in_range;
  logic [24:0]   offset;
  logic [25:0]   where;
  logic [24:0]   sector_base;
  logic          sector_ok;
  logic          prog_hit;
  logic [7:0]    reply;

  assign exch        = (mode_q == MODE_BYTE);
  assign data_ph     = (pos_q[24:2] != '0);
  assign offset      = pos_q - 25'd4;
  assign where       = 26'(addr_q) + 26'(offset);
  assign in_range    = (where < FlashEnd);
  assign sector_base = {1'b0, addr_q[23:SectorBits], {SectorBits{1'b0}}};
  assign sector_ok   = ((sector_base + SectorBytes) <= FlashEnd25);
  assign prog_hit    = exch && data_ph && (cmd_q == CMD_PROGRAM) && in_range;
  assign reply       = (data_ph && (cmd_q == CMD_STATUS)) ? status_q : 8'h00;

  assign status_o.exch            = exch;
  assign status_o.read_hit        = exch && data_ph && (cmd_q == CMD_READ) && in_range;
  assign status_o.erase_go        = (mode_q == MODE_RISE) && (cmd_q == CMD_ERASE_4K)
                                    && sector_ok;
  assign status_o.sweep_end_erase = &sweep_q[SectorBits-1:0];
  assign status_o.sweep_end_clear = (sweep_q == LastAddr);

  // Transaction state update for the latched event.
  always_comb begin
    cmd_d  = cmd_q;
    addr_d = addr_q;
    pos_d  = pos_q;
    if (cmd_i.exec) begin
      case (mode_q)
        MODE_BYTE: begin
          if (pos_q == '0) begin
            cmd_d  = din_q;
            addr_d = '0;
          end else if (!data_ph) begin
            case (pos_q[1:0])
              2'd1:    addr_d[23:16] = addr_q[23:16] | din_q;
              2'd2:    addr_d[15:8]  = addr_q[15:8] | din_q;
              2'd3:    addr_d[7:0]   = addr_q[7:0] | din_q;
              default: addr_d        = addr_q;
            endcase
          end
          if (pos_q != PosMax) begin
            pos_d = pos_q + 25'd1;
          end
        end
        MODE_FALL, MODE_RISE: begin
          cmd_d  = '0;
          addr_d = '0;
          pos_d  = '0;
        end
        default: begin
          cmd_d = cmd_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      addr_q   <= '0;
      pos_q    <= '0;
      status_q <= '0;
      sweep_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      cmd_q    <= cmd_d;
      addr_q   <= addr_d;
      pos_q    <= pos_d;
      strobe_q <= cmd_i.out_direct | cmd_i.out_mem;
      if (status_we_i) begin
        status_q <= status_value_i;
      end
      if (cmd_i.erase_load) begin
        sweep_q <= sector_base[AW-1:0];
      end else if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      din_q  <= data_in_i;
    end
    if (cmd_i.out_mem) begin
      data_out_q <= mem_rdata_q;
    end else if (cmd_i.out_direct) begin
      data_out_q <= reply;
    end
  end

  // Single-port array: sweeps write the erased value, programs write the
  // latched byte, and every cycle reads at the same address.
  assign mem_we    = cmd_i.sweep_wr | (cmd_i.exec & prog_hit);
  assign mem_addr  = cmd_i.sweep_wr ? sweep_q : where[AW-1:0];
  assign mem_wdata = cmd_i.sweep_wr ? ErasedByte : din_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flash_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= flash_mem[mem_addr];
  end

  assign strobe_o   = strobe_q;
  assign data_out_o = data_out_q;

  // A program only writes inside the array.
  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && prog_hit) |-> (where < FlashEnd))
    else $error("program write outside the array");

  // An erase sweep starts on a sector boundary.
  a_erase_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.erase_load |=> (sweep_q[SectorBits-1:0] == '0))
    else $error("erase sweep not sector aligned");

  // The status register only changes through a configuration write.
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(status_we_i) |-> $stable(status_q))
    else $error("status register changed without a write");

endmodule

// File: rtl/core/spi_flash_command_engine_unit.sv
// Flash side of an SPI bus, one bus event per word: a byte exchange, a chip
// select fall or a chip select rise. A word is taken when start is high and
// busy is low; a byte exchange returns one word on data_out_o, marked by a
// one-cycle strobe_o, and the receiver cannot hold it off. After reset the
// array is swept to 0xFF one byte a cycle, and busy stays high until the
// whole array is written (configuration writes are still taken). A byte
// exchange then goes through the decode state, and a read data byte that
// hits the array also through the response state, because the single-port
// array has a registered read; a rise that ends a sector erase then sweeps
// the 4096-byte sector to 0xFF one byte a cycle while busy stays high.
module spi_flash_command_engine_unit #(
  parameter int unsigned FLASH_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_in_i,
  output logic       strobe_o,
  output logic [7:0] data_out_o,
  input  logic       status_we_i,
  input  logic [7:0] status_value_i
);
  import sfce_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sfce_dp #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .data_in_i      (data_in_i),
    .status_we_i    (status_we_i),
    .status_value_i (status_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .strobe_o       (strobe_o),
    .data_out_o     (data_out_o)
  );

  // Every result word follows a cycle in which the block was busy.
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result word without preceding work");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // Result words never come in consecutive cycles.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result words back to back");

endmodule
